[sv/spis_pkg.sv]
package spis_pkg;

    // Default sizes of the string store and the query buffer
    localparam int STORE_BYTES_DEF = 4096;
    localparam int MAX_QUERY_DEF   = 256;

    // Field widths of the words on the ports
    localparam int LIMIT_W  = 13;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 13;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

    // Command codes
    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INTERN = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEAR_DONE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

    typedef struct packed {
        logic [1:0] command;
        logic       has_char;
        logic [7:0] char_byte;
        logic       last_char;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  bytes_used;
        logic [COUNT_W-1:0]  bytes_free;
    } out_word_t;

endpackage

[sv/string_pool_intern_search.sv]
// Channel   Direction  Handshake            Word
// in        input      in_valid / in_stall  in_data  (command, has_char, char_byte, last_char)
// out       output     out_valid/ out_stall out_data (status, offset, bytes_used, bytes_free)
// cfg       input      cfg_write            cfg_data (store_limit)
//
// A word without last_char only adds its character to the query. Clear, overflow,
// no room and the unused command finish straight from the idle state. A search
// primes the reads, then scans the bytes of the store, one byte per cycle through
// the store read port. An intern copies the query, then writes the terminator, one
// byte per cycle copied through the query buffer read port into the store write port.
// Reset empties the store at once through the used-byte count; no sweep.
// in_stall is high while a search or copy runs, or while a result waits.
module string_pool_intern_search #(
    parameter int STORE_BYTES = spis_pkg::STORE_BYTES_DEF,
    parameter int MAX_QUERY   = spis_pkg::MAX_QUERY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  spis_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output spis_pkg::out_word_t               out_data,
    input  logic                              cfg_write,
    input  logic [spis_pkg::LIMIT_W-1:0]      cfg_data
);

    localparam int AW  = $clog2(STORE_BYTES);
    localparam int CW  = $clog2(STORE_BYTES + 1);
    localparam int QAW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int QLW = $clog2(MAX_QUERY + 1);
    localparam int LW  = (CW > spis_pkg::LIMIT_W) ? CW : spis_pkg::LIMIT_W;
    localparam int SW  = LW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_SEARCH,
        S_COPY,
        S_TERM
    } state_t;

    state_t                         state_reg, state_next;
    logic [spis_pkg::LIMIT_W-1:0]   limit_reg;
    logic [CW-1:0]                  nf_reg, nf_next;
    logic [QLW-1:0]                 op_len_reg, op_len_next;
    logic [AW-1:0]                  p_reg, p_next;
    logic [AW-1:0]                  start_reg, start_next;
    logic [QLW-1:0]                 j_reg, j_next;
    logic                           match_reg, match_next;
    logic [QLW-1:0]                 k_reg, k_next;
    logic [AW-1:0]                  wptr_reg, wptr_next;
    logic                           pend_reg, pend_next;
    logic                           out_valid_reg, out_valid_next;
    spis_pkg::out_word_t            out_word_reg, out_word_next;

    logic [7:0]                     store_mem [STORE_BYTES];
    logic [7:0]                     store_rdata_reg;
    logic [AW-1:0]                  store_raddr;
    logic                           store_we;
    logic [AW-1:0]                  store_waddr;
    logic [7:0]                     store_wdata;

    logic                           accept;
    logic                           out_take;
    logic [QAW-1:0]                 q_raddr;
    logic [QLW-1:0]                 len_now;
    logic                           ovf_now;
    logic [7:0]                     q_rdata;

    logic [LW-1:0]                  limit_ext;
    logic [LW-1:0]                  eff_lim;
    logic [LW-1:0]                  nf_ext;
    logic [SW-1:0]                  need_end;
    logic                           fits;
    logic [LW-1:0]                  nf_new;
    logic [LW-1:0]                  free_cur;
    logic [LW-1:0]                  free_new;
    logic                           byte_zero;
    logic                           mismatch;
    logic [QLW-1:0]                 j_inc;
    logic                           at_end;

    // Collect the query string
    spis_query #(
        .MAX_QUERY (MAX_QUERY),
        .QAW       (QAW),
        .QLW       (QLW)
    ) u_query (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (accept),
        .item    (in_data),
        .rd_addr (q_raddr),
        .len_now (len_now),
        .ovf_now (ovf_now),
        .rd_data (q_rdata)
    );

    // Handshake
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Saturate the limit to the store size; derive free bytes
    assign limit_ext = LW'(limit_reg);
    assign eff_lim   = (limit_ext > LW'(STORE_BYTES)) ? LW'(STORE_BYTES) : limit_ext;
    assign nf_ext    = LW'(nf_reg);
    assign need_end  = SW'(nf_ext) + SW'(len_now) + SW'(1);
    assign fits      = (need_end <= SW'(eff_lim));
    assign nf_new    = need_end[LW-1:0];
    assign free_cur  = (eff_lim > nf_ext) ? eff_lim - nf_ext : '0;
    assign free_new  = (eff_lim > nf_new) ? eff_lim - nf_new : '0;

    // Scan compare on the bytes just read
    assign byte_zero = (store_rdata_reg == 8'd0);
    assign mismatch  = (j_reg >= op_len_reg) || (store_rdata_reg != q_rdata);
    assign j_inc     = (j_reg == QLW'(MAX_QUERY)) ? j_reg : j_reg + 1'b1;
    assign at_end    = (CW'(p_reg) + CW'(1) == nf_reg);

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        nf_next        = nf_reg;
        op_len_next    = op_len_reg;
        p_next         = p_reg;
        start_next     = start_reg;
        j_next         = j_reg;
        match_next     = match_reg;
        k_next         = k_reg;
        wptr_next      = wptr_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_word_next  = out_word_reg;
        store_raddr    = '0;
        q_raddr        = '0;
        store_we       = 1'b0;
        store_waddr    = wptr_reg;
        store_wdata    = 8'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_data.last_char)
                begin
                    op_len_next = len_now;
                    out_word_next.offset     = '0;
                    out_word_next.bytes_used = spis_pkg::COUNT_W'(nf_ext);
                    out_word_next.bytes_free = spis_pkg::COUNT_W'(free_cur);
                    case (in_data.command)
                        spis_pkg::CMD_CLEAR:
                        begin
                            nf_next                  = '0;
                            out_valid_next           = 1'b1;
                            out_word_next.status     = spis_pkg::ST_CLEAR_DONE;
                            out_word_next.bytes_used = '0;
                            out_word_next.bytes_free = spis_pkg::COUNT_W'(eff_lim);
                        end
                        spis_pkg::CMD_SEARCH:
                        begin
                            if (ovf_now)
                            begin
                                out_valid_next       = 1'b1;
                                out_word_next.status = spis_pkg::ST_TOO_LONG;
                            end
                            else
                            begin
                                state_next = S_PRIME;
                            end
                        end
                        spis_pkg::CMD_INTERN:
                        begin
                            out_valid_next = 1'b1;
                            if (ovf_now)
                            begin
                                out_word_next.status = spis_pkg::ST_TOO_LONG;
                            end
                            else if (fits)
                            begin
                                out_word_next.status     = spis_pkg::ST_OK;
                                out_word_next.offset     = spis_pkg::OFFSET_W'(nf_ext);
                                out_word_next.bytes_used = spis_pkg::COUNT_W'(nf_new);
                                out_word_next.bytes_free = spis_pkg::COUNT_W'(free_new);
                                nf_next    = CW'(nf_new);
                                wptr_next  = nf_reg[AW-1:0];
                                k_next     = '0;
                                pend_next  = 1'b0;
                                state_next = S_COPY;
                            end
                            else
                            begin
                                out_word_next.status = spis_pkg::ST_NO_ROOM;
                            end
                        end
                        default:
                        begin
                            // Unused command: drop the query, no result
                            out_valid_next = out_valid_reg && !out_take;
                        end
                    endcase
                end
            end

            S_PRIME:
            begin
                // Start reads of the first store byte and first query byte
                store_raddr = '0;
                q_raddr     = '0;
                p_next      = '0;
                start_next  = '0;
                j_next      = '0;
                match_next  = 1'b1;
                if (nf_reg == '0)
                begin
                    out_valid_next       = 1'b1;
                    out_word_next.status = spis_pkg::ST_NOT_FOUND;
                    state_next           = S_IDLE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                p_next      = p_reg + 1'b1;
                store_raddr = p_reg + 1'b1;
                if (byte_zero)
                begin
                    if (match_reg && (j_reg == op_len_reg))
                    begin
                        out_valid_next       = 1'b1;
                        out_word_next.status = spis_pkg::ST_OK;
                        out_word_next.offset = spis_pkg::OFFSET_W'(start_reg);
                        state_next           = S_IDLE;
                    end
                    else if (at_end)
                    begin
                        out_valid_next       = 1'b1;
                        out_word_next.status = spis_pkg::ST_NOT_FOUND;
                        state_next           = S_IDLE;
                    end
                    // Advance to the next stored string
                    start_next = p_reg + 1'b1;
                    j_next     = '0;
                    match_next = 1'b1;
                end
                else
                begin
                    if (mismatch)
                    begin
                        match_next = 1'b0;
                    end
                    j_next = j_inc;
                end
                q_raddr = j_next[QAW-1:0];
            end

            S_COPY:
            begin
                // Read query byte k, write the byte read last cycle
                q_raddr = k_reg[QAW-1:0];
                if (pend_reg)
                begin
                    store_we    = 1'b1;
                    store_wdata = q_rdata;
                    wptr_next   = wptr_reg + 1'b1;
                end
                if (k_reg != op_len_reg)
                begin
                    k_next    = k_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_TERM;
                end
            end

            S_TERM:
            begin
                // Write the terminator
                store_we    = 1'b1;
                store_wdata = 8'd0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= spis_pkg::LIMIT_RESET;
            nf_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            op_len_reg    <= '0;
            p_reg         <= '0;
            start_reg     <= '0;
            j_reg         <= '0;
            match_reg     <= 1'b0;
            k_reg         <= '0;
            wptr_reg      <= '0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nf_reg        <= nf_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            op_len_reg    <= op_len_next;
            p_reg         <= p_next;
            start_reg     <= start_next;
            j_reg         <= j_next;
            match_reg     <= match_next;
            k_reg         <= k_next;
            wptr_reg      <= wptr_next;
            out_word_reg  <= out_word_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // String store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_waddr] <= store_wdata;
        end
        store_rdata_reg <= store_mem[store_raddr];
    end

endmodule

[sv/spis_query.sv]
module spis_query #(
    parameter int MAX_QUERY = spis_pkg::MAX_QUERY_DEF,
    parameter int QAW       = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1,
    parameter int QLW       = $clog2(MAX_QUERY + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  spis_pkg::in_word_t   item,
    input  logic [QAW-1:0]       rd_addr,
    output logic [QLW-1:0]       len_now,
    output logic                 ovf_now,
    output logic [7:0]           rd_data
);

    localparam int QDEPTH = 1 << QAW;

    logic [7:0]     qbuf_mem [QDEPTH];
    logic [7:0]     rd_data_reg;
    logic [QLW-1:0] len_reg;
    logic           ovf_reg;
    logic           add_char;
    logic           room;
    logic           wr_en;

    // Collect a character when the word carries a nonzero one
    assign add_char = take && item.has_char && (item.char_byte != 8'd0);
    assign room     = (len_reg != QLW'(MAX_QUERY));
    assign wr_en    = add_char && room;
    assign len_now  = wr_en ? len_reg + 1'b1 : len_reg;
    assign ovf_now  = ovf_reg | (add_char & ~room);
    assign rd_data  = rd_data_reg;

    // Track length and overflow; empty the query after the last word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (take)
        begin
            if (item.last_char)
            begin
                len_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else
            begin
                len_reg <= len_now;
                ovf_reg <= ovf_now;
            end
        end
    end

    // Query buffer: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            qbuf_mem[len_reg[QAW-1:0]] <= item.char_byte;
        end
        rd_data_reg <= qbuf_mem[rd_addr];
    end

endmodule
